// File: hw/rtl/mean_shift_pixel_weight_defines.svh
// Assertion macros shared by the checker files of the pixel weight block.
// Depends on nothing; the including scope provides aclk and aresetn.
`ifndef MEAN_SHIFT_PIXEL_WEIGHT_DEFINES_SVH
`define MEAN_SHIFT_PIXEL_WEIGHT_DEFINES_SVH

// Check a property outside reset.
`define MSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/msp_pkg.sv
// Shared types, constants and arithmetic step functions of the pixel weight block.
// Depends on nothing.
`timescale 1ns / 1ps
package msp_pkg;

    localparam int NUM_BINS = 4096;
    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS = 4;
    localparam int SQRT_STAGES = 4;
    localparam int SQRT_STEPS = 4;
    localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_PIXEL        = 2'd0,
        REQ_WRITE_TARGET = 2'd1,
        REQ_WRITE_CAND   = 2'd2,
        REQ_UNUSED       = 2'd3
    } req_type_t;

    // Side information that travels with each pixel request.
    typedef struct packed {
        logic        valid;
        logic        in_kernel;
        logic        zero_cand;
        logic        bypass;
        logic [15:0] fixed_w;
    } meta_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] quo;
    } div_state_t;

    typedef struct packed {
        logic [31:0] rad;
        logic [16:0] rem;
        logic [15:0] root;
    } sqrt_state_t;

    // One restoring division step: bring in the next dividend bit.
    function automatic div_state_t div_step(div_state_t s, logic [15:0] d);
        logic [16:0] sh;
        div_state_t  r;
        sh = {s.rem, s.quo[31]};
        r.quo = {s.quo[30:0], 1'b0};
        if (sh >= {1'b0, d}) begin
            sh = sh - {1'b0, d};
            r.quo[0] = 1'b1;
        end
        r.rem = sh[15:0];
        return r;
    endfunction

    // One digit of the square root: bring in the next two radicand bits.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
        logic [18:0] sh;
        logic [18:0] trial;
        sqrt_state_t r;
        sh = {s.rem, s.rad[31:30]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[29:0], 2'b00};
        if (sh >= trial) begin
            sh = sh - trial;
            r.root = {s.root[14:0], 1'b1};
        end else begin
            r.root = {s.root[14:0], 1'b0};
        end
        r.rem = sh[16:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/mean_shift_pixel_weight.sv
// Mean-shift pixel weight: sqrt(target[bin] / candidate[bin]) in unsigned Q8.8.
// A pixel request can enter every cycle while the pipeline is not stalled; its weight
// passes through the histogram memory read register, eight stages of the divider (four
// quotient bits each), four stages of the square root (four root digits each) and the
// output register. Bin writes take effect for the very next request and give no result.
// When the result consumer stalls, the whole pipeline holds and s_tready drops.
// The histogram memories have no reset; bins must be written before use.
`timescale 1ns / 1ps
module mean_shift_pixel_weight (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // bin_index[11:0], kernel_value[27:12], hist_value[43:28]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // weight[15:0]
    output logic [1:0]  m_tuser   // inside_kernel[0], zero_candidate[1]
);
    import msp_pkg::*;

    logic              advance;
    logic              accept;
    req_type_t         req;
    logic [IDX_W-1:0]  bin_index;
    logic signed [15:0] kernel_value;
    logic [15:0]       hist_value;
    logic [15:0]       target_q;
    logic [15:0]       cand_q;
    meta_t             rd_meta_reg;
    meta_t             div_meta_in;
    meta_t             div_meta_out;
    meta_t             sqrt_meta_out;
    logic [31:0]       quotient;
    logic [15:0]       root;
    logic              m_valid_reg;
    logic [15:0]       m_weight_reg;
    logic [1:0]        m_flags_reg;

    assign req          = req_type_t'(s_tuser);
    assign bin_index    = s_tdata[11:0];
    assign kernel_value = s_tdata[27:12];
    assign hist_value   = s_tdata[43:28];

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    msp_hist_mem u_mem (
        .aclk      (aclk),
        .advance   (advance),
        .wr_target (accept && req == REQ_WRITE_TARGET),
        .wr_cand   (accept && req == REQ_WRITE_CAND),
        .addr      (bin_index),
        .wr_data   (hist_value),
        .target_q  (target_q),
        .cand_q    (cand_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_meta_reg.valid <= 1'b0;
        end else if (advance) begin
            rd_meta_reg.valid <= accept && req == REQ_PIXEL;
        end
        if (advance) begin
            rd_meta_reg.in_kernel <= kernel_value > 16'sd0;
            rd_meta_reg.zero_cand <= 1'b0;
            rd_meta_reg.bypass    <= 1'b0;
            rd_meta_reg.fixed_w   <= 16'h0000;
        end
    end

    // Settle the special cases once the bins are known.
    always_comb begin
        div_meta_in = rd_meta_reg;
        div_meta_in.zero_cand = rd_meta_reg.in_kernel && cand_q == 16'h0000;
        div_meta_in.bypass    = !rd_meta_reg.in_kernel || cand_q == 16'h0000;
        div_meta_in.fixed_w   = (div_meta_in.zero_cand && target_q != 16'h0000)
                                ? WEIGHT_MAX : 16'h0000;
    end

    msp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .meta_in  (div_meta_in),
        .target   (target_q),
        .cand     (cand_q),
        .meta_out (div_meta_out),
        .quotient (quotient)
    );

    msp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .meta_in  (div_meta_out),
        .radicand (quotient),
        .meta_out (sqrt_meta_out),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= sqrt_meta_out.valid;
        end
        if (advance) begin
            m_weight_reg <= sqrt_meta_out.bypass ? sqrt_meta_out.fixed_w : root;
            m_flags_reg  <= {sqrt_meta_out.zero_cand, sqrt_meta_out.in_kernel};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_weight_reg;
    assign m_tuser  = m_flags_reg;
endmodule

// File: hw/rtl/msp_hist_mem.sv
// Target and candidate histogram memories with registered reads.
// Depends on msp_pkg.
`timescale 1ns / 1ps
module msp_hist_mem (
    input  logic                     aclk,
    input  logic                     advance,
    input  logic                     wr_target,
    input  logic                     wr_cand,
    input  logic [msp_pkg::IDX_W-1:0] addr,
    input  logic [15:0]              wr_data,
    output logic [15:0]              target_q,
    output logic [15:0]              cand_q
);
    import msp_pkg::*;

    logic [15:0] target_mem [NUM_BINS];
    logic [15:0] cand_mem   [NUM_BINS];
    logic [15:0] target_q_reg;
    logic [15:0] cand_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_target) begin
            target_mem[addr] <= wr_data;
        end
        // hold read data while the pipeline is stalled
        if (advance) begin
            target_q_reg <= target_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_cand) begin
            cand_mem[addr] <= wr_data;
        end
        if (advance) begin
            cand_q_reg <= cand_mem[addr];
        end
    end

    assign target_q = target_q_reg;
    assign cand_q   = cand_q_reg;
endmodule

// File: hw/rtl/msp_divider.sv
// Pipelined restoring divider: (target << 16) / candidate, four bits per stage.
// Depends on msp_pkg.
`timescale 1ns / 1ps
module msp_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  msp_pkg::meta_t      meta_in,
    input  logic [15:0]         target,
    input  logic [15:0]         cand,
    output msp_pkg::meta_t      meta_out,
    output logic [31:0]         quotient
);
    import msp_pkg::*;

    meta_t      meta_reg  [DIV_STAGES];
    div_state_t state_reg [DIV_STAGES];
    logic [15:0] dvs_reg  [DIV_STAGES];
    div_state_t state_next [DIV_STAGES];

    always_comb begin
        div_state_t s;
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                s.rem = 16'h0000;
                s.quo = {target, 16'h0000};
            end else begin
                s = state_reg[i-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                s = div_step(s, (i == 0) ? cand : dvs_reg[i-1]);
            end
            state_next[i] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                meta_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                meta_reg[i] <= (i == 0) ? meta_in : meta_reg[i-1];
            end
        end
        if (advance) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                state_reg[i] <= state_next[i];
                dvs_reg[i]   <= (i == 0) ? cand : dvs_reg[i-1];
            end
        end
    end

    assign meta_out = meta_reg[DIV_STAGES-1];
    assign quotient = state_reg[DIV_STAGES-1].quo;
endmodule

// File: hw/rtl/msp_sqrt.sv
// Pipelined digit-by-digit integer square root of a 32-bit value, four digits per stage.
// Depends on msp_pkg.
`timescale 1ns / 1ps
module msp_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  msp_pkg::meta_t meta_in,
    input  logic [31:0]    radicand,
    output msp_pkg::meta_t meta_out,
    output logic [15:0]    root
);
    import msp_pkg::*;

    meta_t       meta_reg   [SQRT_STAGES];
    sqrt_state_t state_reg  [SQRT_STAGES];
    sqrt_state_t state_next [SQRT_STAGES];

    always_comb begin
        sqrt_state_t s;
        for (int i = 0; i < SQRT_STAGES; i++) begin
            if (i == 0) begin
                s.rad  = radicand;
                s.rem  = 17'h00000;
                s.root = 16'h0000;
            end else begin
                s = state_reg[i-1];
            end
            for (int k = 0; k < SQRT_STEPS; k++) begin
                s = sqrt_step(s);
            end
            state_next[i] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                meta_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                meta_reg[i] <= (i == 0) ? meta_in : meta_reg[i-1];
            end
        end
        if (advance) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                state_reg[i] <= state_next[i];
            end
        end
    end

    assign meta_out = meta_reg[SQRT_STAGES-1];
    assign root     = state_reg[SQRT_STAGES-1].root;
endmodule

// File: hw/rtl/msp_checker.sv
// Port-level checks of the pixel weight block, bound to the top level.
// Depends on mean_shift_pixel_weight_defines.svh.
`timescale 1ns / 1ps
`include "mean_shift_pixel_weight_defines.svh"
module msp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    `MSP_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")
    `MSP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `MSP_ASSERT(a_zero_needs_inside, m_tvalid && m_tuser[1] |-> m_tuser[0], "zero candidate outside kernel")
    `MSP_ASSERT(a_outside_zero, m_tvalid && !m_tuser[0] |-> m_tdata == 16'h0000, "nonzero weight outside kernel")
    `MSP_ASSERT(a_zero_cand_weight, m_tvalid && m_tuser[1] |-> m_tdata == 16'h0000 || m_tdata == 16'hFFFF, "bad weight for zero candidate")
endmodule

bind mean_shift_pixel_weight msp_checker u_msp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/mean_shift_pixel_weight_tb.sv
// Regression bench for the mean-shift pixel weight block: loads both histograms,
// streams pixel requests and checks each weight against an in-bench predictor.
// Depends on msp_pkg and mean_shift_pixel_weight.
`timescale 1ns / 1ps
module mean_shift_pixel_weight_tb;
    import msp_pkg::*;

    typedef struct packed {
        logic [15:0] weight;
        logic        in_kernel;
        logic        zero_cand;
    } weight_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [15:0] target_hist [NUM_BINS];
    logic [15:0] cand_hist [NUM_BINS];
    bit          target_set [NUM_BINS];
    bit          cand_set [NUM_BINS];
    int          written_bins [$];
    weight_t     pending_weights [$];
    int          mismatches;
    int          received;
    bit          stall_en;

    mean_shift_pixel_weight dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("mean_shift_pixel_weight regression: fail");
        $finish;
    end

    // floor(sqrt(x)), bit by bit
    function automatic logic [31:0] int_root(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 32;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= root + b) begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root[31:0];
    endfunction

    function automatic weight_t predict_weight(logic [11:0] bin, logic [15:0] kv);
        weight_t     w;
        logic [15:0] t;
        logic [15:0] c;
        logic [31:0] r;
        w = '0;
        if ($signed(kv) > 0) begin
            w.in_kernel = 1'b1;
            t = target_hist[bin];
            c = cand_hist[bin];
            if (c == 0) begin
                w.zero_cand = 1'b1;
                w.weight = (t != 0) ? WEIGHT_MAX : 16'd0;
            end else begin
                r = int_root(({48'd0, t} << 16) / c);
                w.weight = (r > 32'hFFFF) ? WEIGHT_MAX : r[15:0];
            end
        end
        return w;
    endfunction

    task automatic send_request(req_type_t rt, logic [11:0] bin, logic [15:0] kv,
                                logic [15:0] hv);
        int gap;
        gap = stall_en ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= {4'd0, hv, kv, bin};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // update the predictor on acceptance, in stream order
        case (rt)
            REQ_WRITE_TARGET: begin
                target_hist[bin] = hv;
                if (!target_set[bin] && cand_set[bin]) written_bins.push_back(bin);
                target_set[bin] = 1;
            end
            REQ_WRITE_CAND: begin
                cand_hist[bin] = hv;
                if (!cand_set[bin] && target_set[bin]) written_bins.push_back(bin);
                cand_set[bin] = 1;
            end
            REQ_PIXEL: pending_weights.push_back(predict_weight(bin, kv));
            default: ;
        endcase
    endtask

    task automatic write_bin(logic [11:0] bin, logic [15:0] t, logic [15:0] c);
        send_request(REQ_WRITE_TARGET, bin, 16'($urandom), t);
        send_request(REQ_WRITE_CAND, bin, 16'($urandom), c);
    endtask

    function automatic logic [11:0] pick_bin();
        return 12'(written_bins[$urandom_range(0, written_bins.size() - 1)]);
    endfunction

    task automatic wait_drain();
        // drop the request line while the pipe empties
        s_tvalid <= 1'b0;
        while (pending_weights.size() != 0) @(posedge aclk);
    endtask

    // receiver: random wait per result and in-order compare
    initial begin
        weight_t exp_w;
        int      gap;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            gap = stall_en ? $urandom_range(0, 7) : 0;
            repeat (gap) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_tvalid)) @(posedge aclk);
            received++;
            if (pending_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %b", m_tdata, m_tuser);
            end else begin
                exp_w = pending_weights.pop_front();
                if (m_tdata !== exp_w.weight || m_tuser[0] !== exp_w.in_kernel ||
                    m_tuser[1] !== exp_w.zero_cand) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: exp %h/%b/%b got %h/%b/%b",
                            exp_w.weight, exp_w.in_kernel, exp_w.zero_cand,
                            m_tdata, m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    task automatic test_extremes();
        write_bin(12'd0, 16'hFFFF, 16'd1);
        write_bin(12'd4095, 16'd1, 16'hFFFF);
        write_bin(12'd1, 16'd0, 16'd0);
        write_bin(12'd2, 16'd5, 16'd0);
        write_bin(12'd3, 16'd0, 16'd7);
        write_bin(12'd4, 16'h8000, 16'h8000);
        send_request(REQ_PIXEL, 12'd0, 16'h7FFF, 16'hFFFF);
        send_request(REQ_PIXEL, 12'd4095, 16'd1, 16'd0);
        send_request(REQ_PIXEL, 12'd1, 16'd5, 16'd0);
        send_request(REQ_PIXEL, 12'd2, 16'd5, 16'd0);
        send_request(REQ_PIXEL, 12'd3, 16'd5, 16'd0);
        send_request(REQ_PIXEL, 12'd4, 16'd5, 16'd0);
        send_request(REQ_PIXEL, 12'd0, 16'd0, 16'd0);
        send_request(REQ_PIXEL, 12'd0, 16'h8000, 16'd0);
        send_request(REQ_PIXEL, 12'd0, 16'hFFFF, 16'd0);
        send_request(REQ_UNUSED, 12'hFFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_PIXEL, 12'd4095, 16'h7FFF, 16'd0);
    endtask

    task automatic test_write_then_read();
        // back-to-back rewrite must be seen by the next pixel
        write_bin(12'd5, 16'd100, 16'd400);
        send_request(REQ_PIXEL, 12'd5, 16'd3, 16'd0);
        write_bin(12'd5, 16'd400, 16'd100);
        send_request(REQ_PIXEL, 12'd5, 16'd3, 16'd0);
    endtask

    task automatic test_random(int n);
        int          k;
        int          sel;
        logic [15:0] kv;
        logic [15:0] hv;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            hv = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
            if (sel < 12) begin
                write_bin(12'($urandom), hv, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom));
            end else if (sel < 18) begin
                send_request($urandom_range(0, 1) ? REQ_WRITE_TARGET : REQ_WRITE_CAND,
                             pick_bin(), 16'($urandom), hv);
            end else if (sel < 20) begin
                send_request(REQ_UNUSED, 12'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                kv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32767));
                send_request(REQ_PIXEL, pick_bin(), kv, 16'($urandom));
            end
            if (k == n / 2) begin
                // hold the sender until the pipe has emptied
                wait_drain();
                stall_en = 1'b0;
            end else if (k == n / 2 + 150) begin
                stall_en = 1'b1;
            end
        end
    endtask

    initial begin
        mismatches = 0;
        received = 0;
        stall_en = 1'b1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_PIXEL;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_write_then_read();
        test_random(1350);
        wait_drain();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_weights.size() == 0) begin
            $display("mean_shift_pixel_weight regression: pass");
        end else begin
            $display("mean_shift_pixel_weight regression: fail");
        end
        $finish;
    end
endmodule

// File: mean_shift_pixel_weight.f
+incdir+hw/rtl
hw/rtl/msp_pkg.sv
hw/rtl/msp_hist_mem.sv
hw/rtl/msp_divider.sv
hw/rtl/msp_sqrt.sv
hw/rtl/mean_shift_pixel_weight.sv
hw/rtl/msp_checker.sv
bench/mean_shift_pixel_weight_tb.sv
